FILE: hdl/lcdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_pkg: shared types and constants for the LCD cursor command generator
// Request modes, instruction codes, line bases and controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package lcdc_pkg;

    // Display geometry constants
    localparam int MAX_COLUMNS            = 40;
    localparam int ROWS_RESET             = 4;
    localparam int FIRST_CONTROLLER_CELLS = 80;
    localparam int FOLD_CELLS             = 160;

    // Divider: one quotient bit per cycle over an 8-bit cell index
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Line start addresses inside a controller
    localparam logic [6:0] LINE_A_BASE = 7'h00;
    localparam logic [6:0] LINE_B_BASE = 7'h40;

    // Instruction codes
    localparam logic [7:0] INSTR_CLEAR       = 8'h01;
    localparam logic [7:0] INSTR_HOME        = 8'h02;
    localparam logic [7:0] INSTR_SHIFT_LEFT  = 8'h18;
    localparam logic [7:0] INSTR_SHIFT_RIGHT = 8'h1C;
    localparam logic [7:0] INSTR_DISP_OFF    = 8'h08;
    localparam logic [7:0] INSTR_DISP_ON     = 8'h0C;
    localparam logic       INSTR_SET_ADDR    = 1'b1;

    // Register indexes on the config port
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // Output word selector
    localparam logic WORD_FIRST  = 1'b0;
    localparam logic WORD_SECOND = 1'b1;

    typedef enum logic [2:0] {
        MODE_CHAR        = 3'd0,
        MODE_SET_POS     = 3'd1,
        MODE_CLEAR       = 3'd2,
        MODE_HOME        = 3'd3,
        MODE_SHIFT_LEFT  = 3'd4,
        MODE_SHIFT_RIGHT = 3'd5,
        MODE_DISP_OFF    = 3'd6,
        MODE_DISP_ON     = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PUT0,
        ST_WAIT0,
        ST_PUT1,
        ST_WAIT1
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic put;
        logic word_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_taken;
        logic two_words;
    } dp_status_t;

    // Fixed instruction code of a single-instruction mode
    function automatic logic [7:0] instr_code(input mode_t m);
        logic [7:0] code;
        case (m)
            MODE_CLEAR:       code = INSTR_CLEAR;
            MODE_HOME:        code = INSTR_HOME;
            MODE_SHIFT_LEFT:  code = INSTR_SHIFT_LEFT;
            MODE_SHIFT_RIGHT: code = INSTR_SHIFT_RIGHT;
            MODE_DISP_OFF:    code = INSTR_DISP_OFF;
            default:          code = INSTR_DISP_ON;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/lcdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_div: iterative cell / columns divider
// Restoring division, one quotient bit per cycle; gives line and column.
// ----------------------------------------------------------------------------
module lcdc_div
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [5:0] divisor,
    output logic       busy,
    output logic [7:0] quotient,
    output logic [5:0] remainder
);

    logic                           busy_reg, busy_next;
    logic [lcdc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                     quo_reg, quo_next;
    logic [5:0]                     rem_reg, rem_next;
    logic [6:0]                     trial;
    logic [6:0]                     diff;
    logic                           fits;

    // One restoring step
    assign trial = {rem_reg, quo_reg[7]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = lcdc_pkg::DIV_CNT_W'(lcdc_pkg::DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[6:0], fits};
            rem_next  = fits ? diff[5:0] : trial[5:0];
            cnt_next  = cnt_reg - lcdc_pkg::DIV_CNT_W'(1);
            busy_next = (cnt_reg != lcdc_pkg::DIV_CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/lcdc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_dp: cursor datapath
// Holds the cursor, the latched request and the output word register, and
// maps the cursor cell to a controller line address.
// ----------------------------------------------------------------------------
module lcdc_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcdc_pkg::dp_cmd_t    cmd,
    output lcdc_pkg::dp_status_t status,
    input  logic [5:0]           columns,
    input  logic [2:0]           rows,
    input  logic                 cfg_clear,
    input  logic [2:0]           mode,
    input  logic [7:0]           char_code,
    input  logic [7:0]           target_cell,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 is_data,
    output logic [7:0]           byte_value,
    output logic                 select_first,
    output logic                 select_second,
    output logic [7:0]           cursor_cell,
    output logic                 last
);

    lcdc_pkg::mode_t mode_in;
    lcdc_pkg::mode_t mode_reg;
    logic [7:0]      char_reg;
    logic            first_reg;
    logic [7:0]      cursor_reg, cursor_next;
    logic            out_valid_reg, out_valid_next;
    logic            is_data_reg, is_data_next;
    logic [7:0]      byte_reg, byte_next;
    logic            sel_first_reg, sel_first_next;
    logic            sel_second_reg, sel_second_next;
    logic            last_reg, last_next;

    logic [5:0]      eff_cols;
    logic [8:0]      cell_count;
    logic [8:0]      adv9;
    logic [7:0]      adv;
    logic            div_busy;
    logic [7:0]      line_y;
    logic [5:0]      col_x;
    logic [7:0]      y_adj;
    logic [6:0]      addr7;
    logic [7:0]      set_addr;
    logic            line_start;

    assign mode_in = lcdc_pkg::mode_t'(mode);

    // Geometry
    assign eff_cols   = (columns == 6'd0) ? 6'd1 : columns;
    assign cell_count = {3'b000, columns} * {6'b000000, rows};

    // Cursor advance with wrap
    assign adv9 = {1'b0, cursor_reg} + 9'd1;
    assign adv  = (adv9 >= cell_count || adv9[8]) ? 8'd0 : adv9[7:0];

    // Cursor register
    always_comb
    begin
        cursor_next = cursor_reg;
        if (cfg_clear)
        begin
            cursor_next = '0;
        end
        else if (cmd.load)
        begin
            case (mode_in)
                lcdc_pkg::MODE_CHAR:    cursor_next = adv;
                lcdc_pkg::MODE_SET_POS: cursor_next = target_cell;
                lcdc_pkg::MODE_CLEAR:   cursor_next = '0;
                lcdc_pkg::MODE_HOME:    cursor_next = '0;
                default:                cursor_next = cursor_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode_in;
            char_reg  <= char_code;
            first_reg <= (cursor_reg < 8'(lcdc_pkg::FIRST_CONTROLLER_CELLS));
        end
    end

    // Line / column of the new cursor
    lcdc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (cursor_reg),
        .divisor   (eff_cols),
        .busy      (div_busy),
        .quotient  (line_y),
        .remainder (col_x)
    );

    // Line address; the folded display reuses lines 0 and 1
    always_comb
    begin
        y_adj = line_y;
        if (cell_count == 9'(lcdc_pkg::FOLD_CELLS) && line_y > 8'd1)
        begin
            y_adj = line_y - 8'd2;
        end
        case (y_adj)
            8'd0:    addr7 = lcdc_pkg::LINE_A_BASE + {1'b0, col_x};
            8'd1:    addr7 = lcdc_pkg::LINE_B_BASE + {1'b0, col_x};
            8'd2:    addr7 = lcdc_pkg::LINE_A_BASE + {1'b0, eff_cols} + {1'b0, col_x};
            default: addr7 = lcdc_pkg::LINE_B_BASE + {1'b0, eff_cols} + {1'b0, col_x};
        endcase
    end

    assign set_addr   = {lcdc_pkg::INSTR_SET_ADDR, addr7};
    assign line_start = (col_x == 6'd0);

    // Output word select
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        is_data_next    = is_data_reg;
        byte_next       = byte_reg;
        sel_first_next  = sel_first_reg;
        sel_second_next = sel_second_reg;
        last_next       = last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.put)
        begin
            out_valid_next  = 1'b1;
            is_data_next    = 1'b0;
            sel_first_next  = 1'b1;
            sel_second_next = 1'b1;
            last_next       = 1'b1;
            byte_next       = set_addr;
            if (cmd.word_sel == lcdc_pkg::WORD_FIRST)
            begin
                case (mode_reg)
                    lcdc_pkg::MODE_CHAR:
                    begin
                        is_data_next    = 1'b1;
                        byte_next       = char_reg;
                        sel_first_next  = first_reg;
                        sel_second_next = ~first_reg;
                        last_next       = ~line_start;
                    end
                    lcdc_pkg::MODE_SET_POS:
                    begin
                        byte_next = set_addr;
                    end
                    default:
                    begin
                        byte_next = lcdc_pkg::instr_code(mode_reg);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_data_reg    <= is_data_next;
        byte_reg       <= byte_next;
        sel_first_reg  <= sel_first_next;
        sel_second_reg <= sel_second_next;
        last_reg       <= last_next;
    end

    // Status to controller
    assign status.need_div  = (mode_in == lcdc_pkg::MODE_CHAR) ||
                              (mode_in == lcdc_pkg::MODE_SET_POS);
    assign status.div_busy  = div_busy;
    assign status.out_taken = out_valid_reg && out_ready;
    assign status.two_words = (mode_reg == lcdc_pkg::MODE_CHAR) && line_start;

    assign out_valid     = out_valid_reg;
    assign is_data       = is_data_reg;
    assign byte_value    = byte_reg;
    assign select_first  = sel_first_reg;
    assign select_second = sel_second_reg;
    assign cursor_cell   = cursor_reg;
    assign last          = last_reg;

endmodule

FILE: hdl/lcdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdc_ctrl: request sequencer
// Accepts a request, runs the divider when an address is needed and
// issues one or two output words.
// ----------------------------------------------------------------------------
module lcdc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lcdc_pkg::dp_status_t status,
    output lcdc_pkg::dp_cmd_t    cmd
);

    lcdc_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcdc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.put       = 1'b0;
        cmd.word_sel  = lcdc_pkg::WORD_FIRST;
        in_ready      = 1'b0;
        case (state_reg)
            lcdc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.need_div ? lcdc_pkg::ST_DIV_START
                                                 : lcdc_pkg::ST_PUT0;
                end
            end
            lcdc_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = lcdc_pkg::ST_DIV_WAIT;
            end
            lcdc_pkg::ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = lcdc_pkg::ST_PUT0;
                end
            end
            lcdc_pkg::ST_PUT0:
            begin
                cmd.put    = 1'b1;
                state_next = lcdc_pkg::ST_WAIT0;
            end
            lcdc_pkg::ST_WAIT0:
            begin
                if (status.out_taken)
                begin
                    state_next = status.two_words ? lcdc_pkg::ST_PUT1
                                                  : lcdc_pkg::ST_IDLE;
                end
            end
            lcdc_pkg::ST_PUT1:
            begin
                cmd.put      = 1'b1;
                cmd.word_sel = lcdc_pkg::WORD_SECOND;
                state_next   = lcdc_pkg::ST_WAIT1;
            end
            lcdc_pkg::ST_WAIT1:
            begin
                if (status.out_taken)
                begin
                    state_next = lcdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcdc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/char_lcd_cursor_command_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_command_gen: character LCD cursor tracker
// Turns character and control requests into byte transfers for one or two
// display controllers, with a register port for the display geometry.
// ----------------------------------------------------------------------------
// One request is handled at a time, and the next is taken only after its last
// word has left. A display control request (clear, home, shifts, display
// on/off) gives a single instruction word. Character and set-position requests
// first run the cell index through an 8-step divider to find line and column
// before their first word. A character that lands the cursor on a line start
// adds a set-address word. Writing columns or rows homes the cursor.
module char_lcd_cursor_command_gen
(
    input  logic        clk,
    input  logic        rst_n,
    // Config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  target_cell,
    // Transfer channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_data,
    output logic [7:0]  byte_value,
    output logic        select_first,
    output logic        select_second,
    output logic [7:0]  cursor_cell,
    output logic        last
);

    logic                 cfg_wr;
    logic [5:0]           columns_reg;
    logic [2:0]           rows_reg;
    lcdc_pkg::dp_cmd_t    cmd;
    lcdc_pkg::dp_status_t status;

    // Register write strobe
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= 6'(lcdc_pkg::MAX_COLUMNS);
            rows_reg    <= 3'(lcdc_pkg::ROWS_RESET);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == lcdc_pkg::REG_COLUMNS)
            begin
                columns_reg <= pwdata[5:0];
            end
            else
            begin
                rows_reg <= pwdata[2:0];
            end
        end
    end

    // Readback
    assign prdata = (paddr[2] == lcdc_pkg::REG_ROWS) ? {29'd0, rows_reg}
                                                      : {26'd0, columns_reg};

    lcdc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lcdc_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .columns       (columns_reg),
        .rows          (rows_reg),
        .cfg_clear     (cfg_wr),
        .mode          (mode),
        .char_code     (char_code),
        .target_cell   (target_cell),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_data       (is_data),
        .byte_value    (byte_value),
        .select_first  (select_first),
        .select_second (select_second),
        .cursor_cell   (cursor_cell),
        .last          (last)
    );

    // No word is pending while a new request can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("word pending while idle");

    // Instructions go to both controllers
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_data) |-> (select_first && select_second))
        else $error("instruction not sent to both controllers");

    // Data goes to exactly one controller
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_data) |-> (select_first != select_second))
        else $error("data strobe select wrong");

    // Clear and home put the cursor at cell zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready &&
         (mode == lcdc_pkg::MODE_CLEAR || mode == lcdc_pkg::MODE_HOME))
        |=> (cursor_cell == 8'd0))
        else $error("cursor not homed");

endmodule
